### design/pptpb_pkg.sv
// Shared types and constants for the point-to-plane projection block.
// No dependencies; every other design file but pptpb_div_pipe imports this package.
package pptpb_pkg;

    localparam int PNT_W = 32;   // Q16.16 point coordinate
    localparam int CMP_W = 16;   // Q2.14 vector component
    localparam int VEC_W = 48;   // three packed components
    localparam int NN_W  = 32;   // squared norms and Gram terms, unsigned
    localparam int HW_W  = 33;   // signed cross term of the basis
    localparam int DET_W = 64;   // Gram determinant, unsigned
    localparam int QA_W  = 49;   // quotient bits of the projection divide
    localparam int XA_W  = 64;   // dividend of the projection divide
    localparam int QB_W  = 32;   // quotient bits of the coordinate divide
    localparam int NB_W  = DET_W + QB_W;

    typedef enum logic [1:0] {
        REG_NORMAL   = 2'd0,
        REG_HORIZON  = 2'd1,
        REG_VERTICAL = 2'd2,
        REG_OFFSET   = 2'd3
    } cfg_reg_t;

    localparam logic [VEC_W-1:0] NORMAL_RST   = 48'h4000_0000_0000;
    localparam logic [VEC_W-1:0] HORIZON_RST  = 48'h0000_0000_4000;
    localparam logic [VEC_W-1:0] VERTICAL_RST = 48'h0000_C000_0000;
    localparam logic [PNT_W-1:0] OFFSET_RST   = 32'h0000_0000;

    // Quantities that depend on the configuration only.
    typedef struct packed {
        logic [NN_W-1:0]        nn;
        logic [NN_W-1:0]        hh;
        logic [NN_W-1:0]        ww;
        logic signed [HW_W-1:0] hw;
        logic [DET_W-1:0]       det;
        logic                   degen;
    } basis_t;

    // Sign of a coordinate numerator and its coarse overflow check.
    typedef struct packed {
        logic neg;
        logic big;
    } coord_flags_t;

endpackage

### design/pptpb_gram.sv
// Derives norms, Gram terms and determinant from the configuration registers.
// Depends on pptpb_pkg. Free-running six-stage pipeline.
module pptpb_gram
    import pptpb_pkg::*;
(
    input  logic             clk,
    input  logic [VEC_W-1:0] normal,
    input  logic [VEC_W-1:0] horizon,
    input  logic [VEC_W-1:0] vertical,
    output basis_t           basis
);

    logic signed [CMP_W-1:0] n_c [3];
    logic signed [CMP_W-1:0] h_c [3];
    logic signed [CMP_W-1:0] w_c [3];

    logic signed [31:0] nsq_reg [3], nsq_next [3];
    logic signed [31:0] hsq_reg [3], hsq_next [3];
    logic signed [31:0] wsq_reg [3], wsq_next [3];
    logic signed [31:0] hwp_reg [3], hwp_next [3];

    logic [NN_W-1:0]        nn_reg, nn_next;
    logic [NN_W-1:0]        hh_reg, hh_next;
    logic [NN_W-1:0]        ww_reg, ww_next;
    logic signed [HW_W-1:0] hw_reg, hw_next;
    logic [NN_W-1:0]        hwm_reg, hwm_next;
    logic [DET_W-1:0]       hhww_reg, hhww_next;
    logic [DET_W-1:0]       hw2_reg, hw2_next;
    logic [DET_W-1:0]       det_reg, det_next;
    logic                   degen_reg, degen_next;
    logic signed [33:0]     sum_n, sum_h, sum_w, sum_x;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_c[i] = normal[CMP_W*i +: CMP_W];
            h_c[i] = horizon[CMP_W*i +: CMP_W];
            w_c[i] = vertical[CMP_W*i +: CMP_W];
            nsq_next[i] = 32'(n_c[i]) * 32'(n_c[i]);
            hsq_next[i] = 32'(h_c[i]) * 32'(h_c[i]);
            wsq_next[i] = 32'(w_c[i]) * 32'(w_c[i]);
            hwp_next[i] = 32'(h_c[i]) * 32'(w_c[i]);
        end
        sum_n = 34'(nsq_reg[0]) + 34'(nsq_reg[1]) + 34'(nsq_reg[2]);
        sum_h = 34'(hsq_reg[0]) + 34'(hsq_reg[1]) + 34'(hsq_reg[2]);
        sum_w = 34'(wsq_reg[0]) + 34'(wsq_reg[1]) + 34'(wsq_reg[2]);
        sum_x = 34'(hwp_reg[0]) + 34'(hwp_reg[1]) + 34'(hwp_reg[2]);
        nn_next = sum_n[NN_W-1:0];
        hh_next = sum_h[NN_W-1:0];
        ww_next = sum_w[NN_W-1:0];
        hw_next = sum_x[HW_W-1:0];
        hwm_next = hw_reg[HW_W-1] ? NN_W'(-hw_reg) : NN_W'(hw_reg);
        hhww_next = DET_W'(hh_reg) * DET_W'(ww_reg);
        hw2_next = DET_W'(hwm_reg) * DET_W'(hwm_reg);
        // Cauchy-Schwarz keeps this difference non-negative.
        det_next = hhww_reg - hw2_reg;
        degen_next = (nn_reg == '0) || (det_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        nsq_reg   <= nsq_next;
        hsq_reg   <= hsq_next;
        wsq_reg   <= wsq_next;
        hwp_reg   <= hwp_next;
        nn_reg    <= nn_next;
        hh_reg    <= hh_next;
        ww_reg    <= ww_next;
        hw_reg    <= hw_next;
        hwm_reg   <= hwm_next;
        hhww_reg  <= hhww_next;
        hw2_reg   <= hw2_next;
        det_reg   <= det_next;
        degen_reg <= degen_next;
    end

    assign basis.nn    = nn_reg;
    assign basis.hh    = hh_reg;
    assign basis.ww    = ww_reg;
    assign basis.hw    = hw_reg;
    assign basis.det   = det_reg;
    assign basis.degen = degen_reg;

endmodule

### design/pptpb_div_pipe.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on nothing; the caller guarantees the quotient fits QUO_W bits.
module pptpb_div_pipe #(
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 49,
    parameter int SIDE_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [DEN_W+QUO_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       quo,
    output logic [SIDE_W-1:0]      side_out
);

    logic [DEN_W-1:0]  rem_reg   [QUO_W];
    logic [QUO_W-1:0]  low_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];
    logic              valid_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [QUO_W-1:0]  low_in;
        logic [SIDE_W-1:0] side_k;
        logic              valid_k;
        logic [DEN_W:0]    trial;
        logic              fits;
        logic [DEN_W-1:0]  rem_next;
        logic [QUO_W-1:0]  low_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = num[DEN_W+QUO_W-1:QUO_W];
            assign low_in  = num[QUO_W-1:0];
            assign side_k  = side_in;
            assign valid_k = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign low_in  = low_reg[k-1];
            assign side_k  = side_reg[k-1];
            assign valid_k = valid_reg[k-1];
        end

        // Remaining dividend bits shift out of the top of low while
        // quotient bits shift in at the bottom.
        always_comb
        begin
            trial    = {rem_in, low_in[QUO_W-1]};
            fits     = trial >= {1'b0, den};
            rem_next = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            low_next = {low_in[QUO_W-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_k;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_next;
                side_reg[k] <= side_k;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = low_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

### design/pptpb_front.sv
// Plane distance term and the rounded dividend of the projection divide.
// Depends on pptpb_pkg. Five register stages.
module pptpb_front
    import pptpb_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [2:0][PNT_W-1:0]       in_p,
    input  logic                        in_last,
    input  logic [VEC_W-1:0]            normal,
    input  logic [PNT_W-1:0]            offset,
    input  logic [NN_W-1:0]             nn,
    output logic                        out_valid,
    output logic [2:0][XA_W-1:0]        out_x,
    output logic [2:0]                  out_neg,
    output logic [2:0][PNT_W-1:0]       out_p,
    output logic                        out_last
);

    logic [4:0]                  valid_reg, valid_next;
    logic [4:0]                  last_reg, last_next;
    logic [4:0][2:0][PNT_W-1:0]  p_reg, p_next;

    logic signed [CMP_W-1:0] n_c [3];
    logic signed [PNT_W-1:0] p_s [3];

    logic signed [47:0] pn_reg [3], pn_next [3];
    logic signed [45:0] doff_reg, doff_next;
    logic signed [49:0] s_reg, s_next;
    logic signed [41:0] hi_reg [3], hi_next [3];
    logic signed [40:0] lo_reg [3], lo_next [3];
    logic signed [63:0] num_reg [3], num_next [3];
    logic [2:0][XA_W-1:0] x_reg, x_next;
    logic [2:0]           neg_reg, neg_next;

    logic signed [25:0] s_hi;
    logic signed [24:0] s_lo;
    logic signed [65:0] wide [3];
    logic [XA_W-1:0]    half;
    logic [XA_W-1:0]    num_u [3];

    always_comb
    begin
        valid_next = {valid_reg[3:0], in_valid};
        last_next  = {last_reg[3:0], in_last};
        p_next     = {p_reg[3:0], in_p};
        s_hi = s_reg[49:24];
        s_lo = $signed({1'b0, s_reg[23:0]});
        half = {33'd0, nn[NN_W-1:1]};
        for (int i = 0; i < 3; i++)
        begin
            n_c[i]   = normal[CMP_W*i +: CMP_W];
            p_s[i]   = in_p[i];
            pn_next[i] = 48'(p_s[i]) * 48'(n_c[i]);
            hi_next[i] = 42'(s_hi) * 42'(n_c[i]);
            lo_next[i] = 41'(s_lo) * 41'(n_c[i]);
            wide[i]    = $signed({hi_reg[i], 24'd0}) + 66'(lo_reg[i]);
            num_next[i] = wide[i][63:0];
            num_u[i]    = num_reg[i];
            neg_next[i] = num_reg[i][63];
            // Magnitude plus half the divisor: round half away from zero.
            x_next[i]   = neg_next[i] ? (half - num_u[i]) : (num_u[i] + half);
        end
        doff_next = $signed({offset, 14'd0});
        s_next = 50'(pn_reg[0]) + 50'(pn_reg[1]) + 50'(pn_reg[2]) + 50'(doff_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= last_next;
            p_reg    <= p_next;
            pn_reg   <= pn_next;
            doff_reg <= doff_next;
            s_reg    <= s_next;
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            num_reg  <= num_next;
            x_reg    <= x_next;
            neg_reg  <= neg_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_last  = last_reg[4];
    assign out_p     = p_reg[4];
    assign out_x     = x_reg;
    assign out_neg   = neg_reg;

endmodule

### design/pptpb_mid.sv
// Projected point, basis dot products, Cramer numerators and the rounded
// dividends of the coordinate divide. Depends on pptpb_pkg. Nine stages.
module pptpb_mid
    import pptpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0][QA_W-1:0]  in_quo,
    input  logic [2:0]            in_neg,
    input  logic [2:0][PNT_W-1:0] in_p,
    input  logic                  in_last,
    input  logic [VEC_W-1:0]      horizon,
    input  logic [VEC_W-1:0]      vertical,
    input  basis_t                basis,
    output logic                  out_valid,
    output logic [NB_W-1:0]       out_num_u,
    output logic [NB_W-1:0]       out_num_v,
    output coord_flags_t          out_flags_u,
    output coord_flags_t          out_flags_v,
    output logic                  out_last
);

    logic [8:0] valid_reg, valid_next;
    logic [8:0] last_reg, last_next;

    logic signed [CMP_W-1:0] h_c [3];
    logic signed [CMP_W-1:0] w_c [3];
    logic signed [PNT_W-1:0] p_s [3];

    logic signed [50:0]  q_reg [3], q_next [3];
    logic signed [41:0]  ah_reg [3], ah_next [3];
    logic signed [41:0]  al_reg [3], al_next [3];
    logic signed [41:0]  bh_reg [3], bh_next [3];
    logic signed [41:0]  bl_reg [3], bl_next [3];
    logic signed [67:0]  ta_reg [3], ta_next [3];
    logic signed [67:0]  tb_reg [3], tb_next [3];
    logic signed [69:0]  a_reg, a_next;
    logic signed [69:0]  b_reg, b_next;
    logic signed [57:0]  aww_reg [3], aww_next [3];
    logic signed [57:0]  ahw_reg [3], ahw_next [3];
    logic signed [57:0]  bhh_reg [3], bhh_next [3];
    logic signed [57:0]  bhw_reg [3], bhw_next [3];
    logic signed [102:0] paww_reg, paww_next;
    logic signed [102:0] pahw_reg, pahw_next;
    logic signed [102:0] pbhh_reg, pbhh_next;
    logic signed [102:0] pbhw_reg, pbhw_next;
    logic signed [103:0] nu_reg, nu_next;
    logic signed [103:0] nv_reg, nv_next;
    logic [117:0]        mu_reg, mu_next;
    logic [117:0]        mv_reg, mv_next;
    logic                negu_reg, negu_next;
    logic                negv_reg, negv_next;
    logic [NB_W-1:0]     numu_reg, numu_next;
    logic [NB_W-1:0]     numv_reg, numv_next;
    coord_flags_t        flu_reg, flu_next;
    coord_flags_t        flv_reg, flv_next;

    logic signed [25:0]  q_hi [3];
    logic signed [25:0]  q_lo [3];
    logic signed [24:0]  a_lm [3];
    logic signed [24:0]  b_lm [3];
    logic signed [32:0]  ww_s, hh_s;
    logic [117:0]        shu, shv, halfd, limit;

    // Assemble three 24-bit limb products into one wide product.
    function automatic logic signed [102:0] limbs(input logic signed [57:0] x0,
                                                  input logic signed [57:0] x1,
                                                  input logic signed [57:0] x2);
        logic signed [105:0] acc;
        acc = 106'(x0) + 106'($signed({x1, 24'd0})) + $signed({x2, 48'd0});
        return acc[102:0];
    endfunction

    always_comb
    begin
        valid_next = {valid_reg[7:0], in_valid};
        last_next  = {last_reg[7:0], in_last};
        ww_s = $signed({1'b0, basis.ww});
        hh_s = $signed({1'b0, basis.hh});
        for (int i = 0; i < 3; i++)
        begin
            h_c[i] = horizon[CMP_W*i +: CMP_W];
            w_c[i] = vertical[CMP_W*i +: CMP_W];
            p_s[i] = in_p[i];
            q_next[i] = in_neg[i] ? 51'(p_s[i]) + 51'(in_quo[i])
                                  : 51'(p_s[i]) - 51'(in_quo[i]);
            q_hi[i] = q_reg[i][50:25];
            q_lo[i] = $signed({1'b0, q_reg[i][24:0]});
            ah_next[i] = 42'(q_hi[i]) * 42'(h_c[i]);
            al_next[i] = 42'(q_lo[i]) * 42'(h_c[i]);
            bh_next[i] = 42'(q_hi[i]) * 42'(w_c[i]);
            bl_next[i] = 42'(q_lo[i]) * 42'(w_c[i]);
            ta_next[i] = 68'($signed({ah_reg[i], 25'd0})) + 68'(al_reg[i]);
            tb_next[i] = 68'($signed({bh_reg[i], 25'd0})) + 68'(bl_reg[i]);
        end
        a_next = 70'(ta_reg[0]) + 70'(ta_reg[1]) + 70'(ta_reg[2]);
        b_next = 70'(tb_reg[0]) + 70'(tb_reg[1]) + 70'(tb_reg[2]);
        // The top limb carries the sign of the dot product.
        a_lm[0] = $signed({1'b0, a_reg[23:0]});
        a_lm[1] = $signed({1'b0, a_reg[47:24]});
        a_lm[2] = 25'($signed(a_reg[69:48]));
        b_lm[0] = $signed({1'b0, b_reg[23:0]});
        b_lm[1] = $signed({1'b0, b_reg[47:24]});
        b_lm[2] = 25'($signed(b_reg[69:48]));
        for (int i = 0; i < 3; i++)
        begin
            aww_next[i] = 58'(a_lm[i]) * 58'(ww_s);
            ahw_next[i] = 58'(a_lm[i]) * 58'(basis.hw);
            bhh_next[i] = 58'(b_lm[i]) * 58'(hh_s);
            bhw_next[i] = 58'(b_lm[i]) * 58'(basis.hw);
        end
        paww_next = limbs(aww_reg[0], aww_reg[1], aww_reg[2]);
        pahw_next = limbs(ahw_reg[0], ahw_reg[1], ahw_reg[2]);
        pbhh_next = limbs(bhh_reg[0], bhh_reg[1], bhh_reg[2]);
        pbhw_next = limbs(bhw_reg[0], bhw_reg[1], bhw_reg[2]);
        nu_next = 104'(paww_reg) - 104'(pbhw_reg);
        nv_next = 104'(pbhh_reg) - 104'(pahw_reg);
        // Scale by 2^14, take the magnitude and add half the determinant.
        halfd = {55'd0, basis.det[DET_W-1:1]};
        shu = {nu_reg, 14'd0};
        shv = {nv_reg, 14'd0};
        negu_next = nu_reg[103];
        negv_next = nv_reg[103];
        mu_next = negu_next ? (halfd - shu) : (shu + halfd);
        mv_next = negv_next ? (halfd - shv) : (shv + halfd);
        // A quotient of 2^32 or more saturates whatever its sign.
        limit = {22'd0, basis.det, 32'd0};
        flu_next.neg = negu_reg;
        flu_next.big = mu_reg >= limit;
        flv_next.neg = negv_reg;
        flv_next.big = mv_reg >= limit;
        numu_next = mu_reg[NB_W-1:0];
        numv_next = mv_reg[NB_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= last_next;
            q_reg    <= q_next;
            ah_reg   <= ah_next;
            al_reg   <= al_next;
            bh_reg   <= bh_next;
            bl_reg   <= bl_next;
            ta_reg   <= ta_next;
            tb_reg   <= tb_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            aww_reg  <= aww_next;
            ahw_reg  <= ahw_next;
            bhh_reg  <= bhh_next;
            bhw_reg  <= bhw_next;
            paww_reg <= paww_next;
            pahw_reg <= pahw_next;
            pbhh_reg <= pbhh_next;
            pbhw_reg <= pbhw_next;
            nu_reg   <= nu_next;
            nv_reg   <= nv_next;
            mu_reg   <= mu_next;
            mv_reg   <= mv_next;
            negu_reg <= negu_next;
            negv_reg <= negv_next;
            numu_reg <= numu_next;
            numv_reg <= numv_next;
            flu_reg  <= flu_next;
            flv_reg  <= flv_next;
        end
    end

    assign out_valid   = valid_reg[8];
    assign out_last    = last_reg[8];
    assign out_num_u   = numu_reg;
    assign out_num_v   = numv_reg;
    assign out_flags_u = flu_reg;
    assign out_flags_v = flv_reg;

endmodule

### design/project_point_to_plane_basis.sv
// Top level of the point-to-plane projection block: configuration
// registers, pipeline, output skid buffer. Depends on pptpb_pkg and all pptpb_* modules.
//
// Each Q16.16 point is projected orthogonally onto the plane n.p + D = 0 and
// expressed as least-squares coordinates (u, v) in the horizon/vertical basis,
// solved through the 2x2 normal equations with exact wide arithmetic and two
// round-half-away-from-zero divisions. The block takes one point per clock
// cycle while s_tready is high and returns exactly one result per point, in
// order. An accepted point passes through five front stages, a 49-stage
// divider for the projection (one quotient bit per stage, three lanes in
// parallel), nine stages for the dot products and Cramer numerators, a
// 32-stage divider for u and v, and the output register. A two-entry output
// buffer lets the block keep accepting points while a result waits; s_tready
// drops only when both entries are full, and it comes from a register.
// Configuration may be written whenever no point is in flight; derived terms
// (norms, Gram terms, determinant) are registered and settle well before any
// point reaches them. A zero normal or a singular basis gives zero
// coordinates with the degenerate flag; an out-of-range coordinate is
// clipped and sets the saturated flag.
module project_point_to_plane_basis
    import pptpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // point_x [31:0], point_y [63:32], point_z [95:64]
    input  logic        s_tlast,    // final_feature
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // coord_u [31:0], coord_v [63:32]
    output logic [1:0]  m_tuser,    // degenerate [0], saturated [1]
    output logic        m_tlast,    // final_result
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    typedef struct packed {
        logic              last;
        logic              sat;
        logic              degen;
        logic [PNT_W-1:0]  v;
        logic [PNT_W-1:0]  u;
    } result_t;

    logic [VEC_W-1:0] normal_reg, normal_next;
    logic [VEC_W-1:0] horizon_reg, horizon_next;
    logic [VEC_W-1:0] vertical_reg, vertical_next;
    logic [PNT_W-1:0] offset_reg, offset_next;

    basis_t basis;
    logic   en;

    logic                  fr_valid;
    logic [2:0][XA_W-1:0]  fr_x;
    logic [2:0]            fr_neg;
    logic [2:0][PNT_W-1:0] fr_p;
    logic                  fr_last;

    logic [2:0]             da_valid;
    logic [2:0][QA_W-1:0]   da_quo;
    logic [2:0]             da_neg;
    logic [2:0][PNT_W-1:0]  da_p;
    logic [2:0]             da_last;

    logic             md_valid;
    logic [NB_W-1:0]  md_num_u, md_num_v;
    coord_flags_t     md_flags_u, md_flags_v;
    logic             md_last;

    logic             pipe_valid;
    logic             pipe_valid_v;
    logic [QB_W-1:0]  quo_u, quo_v;
    coord_flags_t     fl_u, fl_v;
    logic             pipe_last;

    logic [32:0] clip_u, clip_v;
    result_t     res;

    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    take, push;

    // Configuration registers.
    always_comb
    begin
        normal_next   = normal_reg;
        horizon_next  = horizon_reg;
        vertical_next = vertical_reg;
        offset_next   = offset_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NORMAL:   normal_next   = cfg_data;
                REG_HORIZON:  horizon_next  = cfg_data;
                REG_VERTICAL: vertical_next = cfg_data;
                REG_OFFSET:   offset_next   = cfg_data[PNT_W-1:0];
                default:      normal_next   = normal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg   <= NORMAL_RST;
            horizon_reg  <= HORIZON_RST;
            vertical_reg <= VERTICAL_RST;
            offset_reg   <= OFFSET_RST;
        end
        else
        begin
            normal_reg   <= normal_next;
            horizon_reg  <= horizon_next;
            vertical_reg <= vertical_next;
            offset_reg   <= offset_next;
        end
    end

    pptpb_gram u_gram (
        .clk      (clk),
        .normal   (normal_reg),
        .horizon  (horizon_reg),
        .vertical (vertical_reg),
        .basis    (basis)
    );

    // The whole pipeline moves together; it halts only while the skid entry
    // is occupied, so the last stage never overwrites an undelivered result.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    pptpb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_p      (s_tdata),
        .in_last   (s_tlast),
        .normal    (normal_reg),
        .offset    (offset_reg),
        .nn        (basis.nn),
        .out_valid (fr_valid),
        .out_x     (fr_x),
        .out_neg   (fr_neg),
        .out_p     (fr_p),
        .out_last  (fr_last)
    );

    // One divider lane per axis computes round(s * n_i / n.n).
    for (genvar i = 0; i < 3; i++)
    begin : g_proj
        pptpb_div_pipe #(
            .DEN_W  (NN_W),
            .QUO_W  (QA_W),
            .SIDE_W (PNT_W + 2)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (fr_valid),
            .num       ({(NN_W + QA_W - XA_W)'(0), fr_x[i]}),
            .den       (basis.nn),
            .side_in   ({fr_last, fr_neg[i], fr_p[i]}),
            .out_valid (da_valid[i]),
            .quo       (da_quo[i]),
            .side_out  ({da_last[i], da_neg[i], da_p[i]})
        );
    end

    pptpb_mid u_mid (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (da_valid[0]),
        .in_quo      (da_quo),
        .in_neg      (da_neg),
        .in_p        (da_p),
        .in_last     (da_last[0]),
        .horizon     (horizon_reg),
        .vertical    (vertical_reg),
        .basis       (basis),
        .out_valid   (md_valid),
        .out_num_u   (md_num_u),
        .out_num_v   (md_num_v),
        .out_flags_u (md_flags_u),
        .out_flags_v (md_flags_v),
        .out_last    (md_last)
    );

    pptpb_div_pipe #(
        .DEN_W  (DET_W),
        .QUO_W  (QB_W),
        .SIDE_W (3)
    ) u_div_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (md_valid),
        .num       (md_num_u),
        .den       (basis.det),
        .side_in   ({md_last, md_flags_u}),
        .out_valid (pipe_valid),
        .quo       (quo_u),
        .side_out  ({pipe_last, fl_u})
    );

    pptpb_div_pipe #(
        .DEN_W  (DET_W),
        .QUO_W  (QB_W),
        .SIDE_W (2)
    ) u_div_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (md_valid),
        .num       (md_num_v),
        .den       (basis.det),
        .side_in   (md_flags_v),
        .out_valid (pipe_valid_v),
        .quo       (quo_v),
        .side_out  (fl_v)
    );

    // Clip a quotient magnitude to the signed 32-bit range and apply the
    // sign. Returns the saturation flag above the coordinate.
    function automatic logic [32:0] clip(input logic [QB_W-1:0] quo,
                                         input coord_flags_t fl);
        logic [QB_W-1:0] lim;
        logic [QB_W-1:0] mag;
        logic            sat;
        lim = fl.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat = fl.big || (quo > lim);
        mag = sat ? lim : quo;
        return {sat, fl.neg ? (32'd0 - mag) : mag};
    endfunction

    always_comb
    begin
        clip_u = clip(quo_u, fl_u);
        clip_v = clip(quo_v, fl_v);
        res.last = pipe_last;
        if (basis.degen)
        begin
            res.degen = 1'b1;
            res.sat   = 1'b0;
            res.u     = '0;
            res.v     = '0;
        end
        else
        begin
            res.degen = 1'b0;
            res.sat   = clip_u[32] || clip_v[32];
            res.u     = clip_u[31:0];
            res.v     = clip_v[31:0];
        end
    end

    // Output register plus one skid entry.
    always_comb
    begin
        take            = out_valid_reg && m_tready;
        push            = pipe_valid && en;
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.v, out_reg.u};
    assign m_tuser  = {out_reg.sat, out_reg.degen};
    assign m_tlast  = out_reg.last;

    // The skid entry is only ever filled behind a held output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // A result arriving at a blocked output must be parked, not dropped.
    a_park_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_valid && !skid_valid_reg && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result from the pipeline was not parked in the skid entry");

    // Both lanes of the coordinate divide carry the same item.
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid == pipe_valid_v)
        else $error("u and v divider lanes are out of step");

    // A degenerate result carries zero coordinates and no saturation.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> ((m_tdata == 64'd0) && !m_tuser[1]))
        else $error("degenerate result with nonzero coordinates or saturation");

endmodule
